>>> src/rd_pkg.sv
`default_nettype none

package rd_pkg;

  // input opcodes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [6:0] SCORE_MAX = 7'd100;

  typedef struct packed {
    logic [31:0] test_number;
    logic [63:0] name_first;
    logic [63:0] name_middle;
    logic [31:0] name_last;
    logic [6:0]  score;
  } record_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_LIST
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    record_t   rec;
  } cmd_t;

endpackage

`default_nettype wire

>>> src/rd_front.sv
`default_nettype none

module rd_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    opcode_i,
  input  logic [31:0]   test_number_i,
  input  logic [63:0]   name_first_i,
  input  logic [63:0]   name_middle_i,
  input  logic [31:0]   name_last_i,
  input  logic [6:0]    score_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output rd_pkg::cmd_t  cmd_o
);
  import rd_pkg::*;

  logic      legal;
  cmd_kind_e kind;

  // undefined opcodes are taken and dropped
  always_comb begin
    legal = 1'b1;
    kind  = CMD_LIST;
    unique case (opcode_i)
      OP_PUSH_FRONT: kind = CMD_PUSH_FRONT;
      OP_PUSH_BACK:  kind = CMD_PUSH_BACK;
      OP_POP_FRONT:  kind = CMD_POP_FRONT;
      OP_POP_BACK:   kind = CMD_POP_BACK;
      OP_LIST:       kind = CMD_LIST;
      default:       legal = 1'b0;
    endcase
  end

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i && legal;

  always_comb begin
    cmd_o.kind            = kind;
    cmd_o.rec.test_number = test_number_i;
    cmd_o.rec.name_first  = name_first_i;
    cmd_o.rec.name_middle = name_middle_i;
    cmd_o.rec.name_last   = name_last_i;
    cmd_o.rec.score       = (score_i > SCORE_MAX) ? SCORE_MAX : score_i;
  end

endmodule

`default_nettype wire

>>> src/rd_cmd_fifo.sv
`default_nettype none

module rd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  rd_pkg::cmd_t  wr_cmd_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output rd_pkg::cmd_t  rd_cmd_o
);
  import rd_pkg::*;

  localparam logic [1:0] FifoDepth = 2'd2;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != FifoDepth);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_cmd_o   = slot_q[rd_ptr_q];

  assign do_wr = wr_valid_i && wr_ready_o;
  assign do_rd = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> src/rd_back.sv
`default_nettype none

module rd_back #(
  parameter int unsigned DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  rd_pkg::cmd_t  cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [31:0]   out_test_number_o,
  output logic [63:0]   out_name_first_o,
  output logic [63:0]   out_name_middle_o,
  output logic [31:0]   out_name_last_o,
  output logic [6:0]    out_score_o,
  output logic          last_of_run_o
);
  import rd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_OUT,
    S_LIST_RD,
    S_LIST_OUT
  } state_e;

  state_e        state_q;
  logic [AW-1:0] front_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] walk_q;
  logic          out_valid_q;
  logic [1:0]    status_q;
  record_t       out_rec_q;
  logic          last_q;

  record_t       mem_q [DEPTH];
  record_t       rd_data_q;

  logic          out_free, take, is_full, is_empty, walk_last;
  logic [CW-1:0] offset;
  logic [SW-1:0] sum;
  logic [AW-1:0] pos_fwd, pos_dec, front_inc;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign is_full     = (count_q == CW'(DEPTH));
  assign is_empty    = (count_q == '0);
  assign walk_last   = ((CW'(walk_q) + CW'(1)) == count_q);

  // position = front + offset, wrapped once around the ring
  always_comb begin
    offset = '0;
    if (state_q == S_LIST_RD) begin
      offset = CW'(walk_q);
    end else begin
      case (cmd_i.kind)
        CMD_PUSH_BACK: offset = count_q;
        CMD_POP_BACK:  offset = count_q - CW'(1);
        default:       offset = '0;
      endcase
    end
    sum     = SW'(front_q) + SW'(offset);
    pos_fwd = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
  end

  assign pos_dec   = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  assign wr_en   = take && !is_full &&
                   (cmd_i.kind == CMD_PUSH_FRONT || cmd_i.kind == CMD_PUSH_BACK);
  assign wr_addr = (cmd_i.kind == CMD_PUSH_FRONT) ? pos_dec : pos_fwd;
  assign rd_en   = (take && !is_empty &&
                    (cmd_i.kind == CMD_POP_FRONT || cmd_i.kind == CMD_POP_BACK)) ||
                   (state_q == S_LIST_RD);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_i.rec;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[pos_fwd];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      out_rec_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            unique case (cmd_i.kind) inside
              CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                out_valid_q <= 1'b1;
                out_rec_q   <= '0;
                last_q      <= 1'b1;
                if (is_full) begin
                  status_q <= ST_FULL;
                end else begin
                  status_q <= ST_OK;
                  count_q  <= count_q + CW'(1);
                  if (cmd_i.kind == CMD_PUSH_FRONT) begin
                    front_q <= pos_dec;
                  end
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK: begin
                if (is_empty) begin
                  out_valid_q <= 1'b1;
                  status_q    <= ST_EMPTY;
                  out_rec_q   <= '0;
                  last_q      <= 1'b1;
                end else begin
                  count_q <= count_q - CW'(1);
                  if (cmd_i.kind == CMD_POP_FRONT) begin
                    front_q <= front_inc;
                  end
                  state_q <= S_POP_OUT;
                end
              end
              CMD_LIST: begin
                if (is_empty) begin
                  out_valid_q <= 1'b1;
                  status_q    <= ST_EMPTY;
                  out_rec_q   <= '0;
                  last_q      <= 1'b1;
                end else begin
                  walk_q  <= '0;
                  state_q <= S_LIST_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_POP_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= ST_OK;
            out_rec_q   <= rd_data_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_LIST_RD: begin
          state_q <= S_LIST_OUT;
        end
        S_LIST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= ST_OK;
            out_rec_q   <= rd_data_q;
            last_q      <= walk_last;
            if (walk_last) begin
              state_q <= S_IDLE;
            end else begin
              walk_q  <= walk_q + AW'(1);
              state_q <= S_LIST_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign out_test_number_o = out_rec_q.test_number;
  assign out_name_first_o  = out_rec_q.name_first;
  assign out_name_middle_o = out_rec_q.name_middle;
  assign out_name_last_o   = out_rec_q.name_last;
  assign out_score_o       = out_rec_q.score;
  assign last_of_run_o     = last_q;

endmodule

`default_nettype wire

>>> src/record_deque_top.sv
`default_nettype none

// channel   handshake              payload
// -------   ---------------------  ---------------------------------------------
// request   in_valid_i/in_ready_o  opcode, test number, name (3 parts), score
// result    out_valid_o/out_ready_i status, record fields, last_of_run
//
// a push is answered from idle; a pop and each listed record need a
// registered memory read: one read port and the single output register set
// the pace; the 2-entry command queue lets requests be taken meanwhile
// reset clears front index, count, command queue and output; the record store
// is not cleared and holds no valid bits, so no clearing pass follows reset
// either side may stall at will; a held result stalls the back end, and the
// front once the command queue is full

module record_deque_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] test_number_i,
  input  logic [63:0] name_first_i,
  input  logic [63:0] name_middle_i,
  input  logic [31:0] name_last_i,
  input  logic [6:0]  score_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_test_number_o,
  output logic [63:0] out_name_first_o,
  output logic [63:0] out_name_middle_o,
  output logic [31:0] out_name_last_o,
  output logic [6:0]  out_score_o,
  output logic        last_of_run_o
);
  import rd_pkg::*;

  // front end -> command queue
  logic fe_valid, fe_ready;
  cmd_t fe_cmd;
  // command queue -> back end
  logic be_valid, be_ready;
  cmd_t be_cmd;

  // decode opcode, clamp score, drop undefined opcodes
  rd_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .test_number_i (test_number_i),
    .name_first_i  (name_first_i),
    .name_middle_i (name_middle_i),
    .name_last_i   (name_last_i),
    .score_i       (score_i),
    .cmd_valid_o   (fe_valid),
    .cmd_ready_i   (fe_ready),
    .cmd_o         (fe_cmd)
  );

  // short decoupling queue between front and back
  rd_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_cmd_i   (fe_cmd),
    .rd_valid_o (be_valid),
    .rd_ready_i (be_ready),
    .rd_cmd_o   (be_cmd)
  );

  // ring-buffer store, front index and count, result register
  rd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (be_valid),
    .cmd_ready_o       (be_ready),
    .cmd_i             (be_cmd),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .out_test_number_o (out_test_number_o),
    .out_name_first_o  (out_name_first_o),
    .out_name_middle_o (out_name_middle_o),
    .out_name_last_o   (out_name_last_o),
    .out_score_o       (out_score_o),
    .last_of_run_o     (last_of_run_o)
  );

  // a legal request lands in the command queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i <= OP_LIST) |=> be_valid)
    else $error("accepted request missing from command queue");

  // full and empty answers end their run and carry no record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      last_of_run_o && (out_score_o == '0) && (out_test_number_o == '0))
    else $error("error result carries record data or is not last");

  // stored scores are clamped and the status is never the undefined code 3
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_score_o <= SCORE_MAX) && (status_o != 2'd3))
    else $error("result score or status out of range");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rd_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned RANDOM_REQUESTS = 335;
  localparam int unsigned MAX_SHOWN = 10;
  // length of the quiet tail that follows the last result
  localparam int unsigned SETTLE_CYCLES = 200;

  // one request as the sender sees it, with its own pacing
  typedef struct {
    logic [2:0]  opcode;
    record_t     rec;
    int unsigned gap;         // idle cycles after this request is taken
    bit          wait_drain;  // hold this request until all results are back
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    record_t    rec;
    logic       last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  opcode_i;
  logic [31:0] test_number_i;
  logic [63:0] name_first_i;
  logic [63:0] name_middle_i;
  logic [31:0] name_last_i;
  logic [6:0]  score_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] out_test_number_o;
  logic [63:0] out_name_first_o;
  logic [63:0] out_name_middle_o;
  logic [31:0] out_name_last_o;
  logic [6:0]  out_score_o;
  logic        last_of_run_o;

  record_deque_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .test_number_i     (test_number_i),
    .name_first_i      (name_first_i),
    .name_middle_i     (name_middle_i),
    .name_last_i       (name_last_i),
    .score_i           (score_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .out_test_number_o (out_test_number_o),
    .out_name_first_o  (out_name_first_o),
    .out_name_middle_o (out_name_middle_o),
    .out_name_last_o   (out_name_last_o),
    .out_score_o       (out_score_o),
    .last_of_run_o     (last_of_run_o)
  );

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shared state
  // ---------------------------------------------------------------------------
  request_t    send_queue[$];        // requests waiting to be driven
  result_t     expected_results[$];  // predicted results, oldest first
  int unsigned fail_count;
  int unsigned result_index;

  // shadow deque
  record_t     shadow_store[DEPTH];
  int unsigned shadow_front;
  int unsigned shadow_count;

  // handshakes seen at the last rising edge, read by the falling-edge drivers
  logic        req_taken;
  logic        res_taken;

  // sender and receiver pacing
  int unsigned send_gap_left;
  int unsigned recv_stall_left;
  int unsigned recv_stall_next;
  int unsigned recv_mode_left;
  bit          recv_quiet;
  logic        send_valid_next;
  request_t    send_head;

  // stimulus generator bookkeeping
  int unsigned gen_count;      // occupancy the generator believes in
  int unsigned gen_mode_left;
  bit          gen_quiet;

  // ---------------------------------------------------------------------------
  // deque predictor: updates the shadow and queues the results a request causes
  // ---------------------------------------------------------------------------
  task automatic predict_deque(input logic [2:0] op, input record_t rec);
    result_t     res;
    int unsigned slot;
    res = '0;
    res.status = ST_OK;
    res.last = 1'b1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (rec.score > SCORE_MAX) rec.score = SCORE_MAX;
          if (op == OP_PUSH_FRONT) begin
            shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
            slot = shadow_front;
          end else begin
            slot = (shadow_front + shadow_count) % DEPTH;
          end
          shadow_store[slot] = rec;
          shadow_count++;
        end
        expected_results.push_back(res);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) begin
            slot = shadow_front;
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            slot = (shadow_front + shadow_count - 1) % DEPTH;
          end
          shadow_count--;
          res.rec = shadow_store[slot];
        end
        expected_results.push_back(res);
      end
      OP_LIST: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
          expected_results.push_back(res);
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++) begin
            res.rec = shadow_store[(shadow_front + i) % DEPTH];
            res.last = (i + 1 == shadow_count);
            expected_results.push_back(res);
          end
        end
      end
      default: ; // undefined opcodes cause nothing
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // monitor: request acceptance feeds the predictor, results are checked
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      req_taken <= in_valid_i && in_ready_o;
      res_taken <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        predict_deque(opcode_i, '{test_number_i, name_first_i, name_middle_i,
                                  name_last_i, score_i});
      end
      if (out_valid_o && out_ready_i) begin
        result_t want;
        result_t got;
        got = '{status_o, '{out_test_number_o, out_name_first_o, out_name_middle_o,
                            out_name_last_o, out_score_o}, last_of_run_o};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("result #%0d arrived with nothing expected: status %0d id %h",
                     result_index, got.status, got.rec.test_number);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status ||
              got.rec.test_number !== want.rec.test_number ||
              got.rec.name_first !== want.rec.name_first ||
              got.rec.name_middle !== want.rec.name_middle ||
              got.rec.name_last !== want.rec.name_last ||
              got.rec.score !== want.rec.score ||
              got.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
              $display("result #%0d differs", result_index);
              $display("  expected status %0d id %h name %h_%h_%h score %0d last %0d",
                       want.status, want.rec.test_number, want.rec.name_last,
                       want.rec.name_middle, want.rec.name_first, want.rec.score,
                       want.last);
              $display("  actual   status %0d id %h name %h_%h_%h score %0d last %0d",
                       got.status, got.rec.test_number, got.rec.name_last,
                       got.rec.name_middle, got.rec.name_first, got.rec.score,
                       got.last);
            end
          end
        end
        result_index++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driver: falling edge, one request at a time from send_queue
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // valid is held until the request has been taken
      if (!in_valid_i || req_taken) begin
        send_valid_next = 1'b0;
        if (send_gap_left > 0) begin
          send_gap_left <= send_gap_left - 1;
        end else if (send_queue.size() > 0 &&
                     !(send_queue[0].wait_drain && expected_results.size() > 0)) begin
          send_head = send_queue.pop_front();
          opcode_i      <= send_head.opcode;
          test_number_i <= send_head.rec.test_number;
          name_first_i  <= send_head.rec.name_first;
          name_middle_i <= send_head.rec.name_middle;
          name_last_i   <= send_head.rec.name_last;
          score_i       <= send_head.rec.score;
          send_gap_left <= send_head.gap;
          send_valid_next = 1'b1;
        end
        in_valid_i <= send_valid_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls per result, with stall-free stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      recv_stall_next = recv_stall_left;
      if (res_taken) begin
        if (recv_mode_left == 0) begin
          recv_quiet = ($urandom_range(3) == 0);
          recv_mode_left = $urandom_range(60, 15);
        end else begin
          recv_mode_left--;
        end
        recv_stall_next = recv_quiet ? 0 : $urandom_range(12);
      end
      if (recv_stall_next > 0) begin
        out_ready_i <= 1'b0;
        recv_stall_left <= recv_stall_next - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall_left <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic record_t random_record();
    record_t rec;
    rec.test_number = $urandom;
    rec.name_first  = {$urandom, $urandom};
    rec.name_middle = {$urandom, $urandom};
    rec.name_last   = $urandom;
    // mostly legal grades, sometimes above the clamp point
    rec.score = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 101))
                                         : 7'($urandom_range(100));
    return rec;
  endfunction

  // queue one request, pick its pacing and track the expected occupancy
  task automatic add_request(input logic [2:0] op, input record_t rec,
                             input bit drain = 1'b0);
    request_t req;
    if (gen_mode_left == 0) begin
      gen_quiet = ($urandom_range(3) == 0);
      gen_mode_left = $urandom_range(40, 10);
    end else begin
      gen_mode_left--;
    end
    req.opcode = op;
    req.rec = rec;
    req.gap = gen_quiet ? 0 : $urandom_range(12);
    req.wait_drain = drain;
    send_queue.push_back(req);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_count < DEPTH) gen_count++;
      OP_POP_FRONT, OP_POP_BACK:   if (gen_count > 0) gen_count--;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_done;
    int unsigned phase_left;
    int unsigned phase_kind;   // 0 fill, 1 drain, 2 mixed
    int unsigned pick;
    int unsigned push_share;
    record_t     ones;
    record_t     zeros;
    logic [2:0]  op;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    opcode_i = OP_PUSH_FRONT;
    test_number_i = '0;
    name_first_i = '0;
    name_middle_i = '0;
    name_last_i = '0;
    score_i = '0;
    req_taken = 1'b0;
    res_taken = 1'b0;
    fail_count = 0;
    result_index = 0;
    shadow_front = 0;
    shadow_count = 0;
    send_gap_left = 0;
    recv_stall_left = 0;
    recv_mode_left = 0;
    recv_quiet = 1'b0;
    gen_count = 0;
    gen_mode_left = 0;
    gen_quiet = 1'b0;
    ones = '1;
    zeros = '0;

    // directed: empty deque answers on every read kind
    add_request(OP_POP_FRONT, random_record());
    add_request(OP_POP_BACK, random_record());
    add_request(OP_LIST, random_record());
    // extreme records, grade clamp at and above the limit
    add_request(OP_PUSH_BACK, ones);
    add_request(OP_PUSH_FRONT, zeros);
    ones.score = 7'd100;
    add_request(OP_PUSH_BACK, ones);
    ones.score = 7'd101;
    add_request(OP_PUSH_FRONT, ones);
    ones.score = 7'd99;
    add_request(OP_PUSH_BACK, ones);
    add_request(OP_LIST, random_record());
    add_request(OP_POP_FRONT, random_record());
    add_request(OP_POP_BACK, random_record());
    // undefined opcodes must be dropped silently
    add_request(3'd5, ones);
    add_request(3'd6, random_record());
    add_request(3'd7, zeros);
    add_request(OP_LIST, random_record());
    add_request(OP_POP_FRONT, random_record());
    add_request(OP_POP_BACK, random_record());
    add_request(OP_POP_FRONT, random_record());
    add_request(OP_LIST, random_record());
    // a push at each end, each followed by a single-entry pop
    add_request(OP_PUSH_FRONT, random_record());
    add_request(OP_POP_BACK, random_record());
    add_request(OP_PUSH_BACK, random_record());
    add_request(OP_POP_FRONT, random_record());

    // fill to the limit and beyond, list the full store, after a full drain
    random_done = 0;
    add_request(OP_PUSH_BACK, random_record(), 1'b1);
    random_done++;
    while (gen_count < DEPTH) begin
      add_request($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, random_record());
      random_done++;
    end
    repeat (3) begin
      add_request($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, random_record());
      random_done++;
    end
    add_request(OP_LIST, random_record());
    random_done++;

    // random phases of filling, draining and mixed traffic
    phase_left = 0;
    phase_kind = 2;
    while (random_done < RANDOM_REQUESTS) begin
      if (phase_left == 0) begin
        phase_kind = $urandom_range(2);
        phase_left = $urandom_range(45, 10);
      end
      phase_left--;
      push_share = (phase_kind == 0) ? 80 : (phase_kind == 1) ? 20 : 50;
      pick = $urandom_range(99);
      if (pick < 4) begin
        op = 3'($urandom_range(7, 5));
      end else if (pick < 14) begin
        op = OP_LIST;
      end else if ($urandom_range(99) < push_share) begin
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      add_request(op, random_record(), $urandom_range(49) == 0);
      if (op <= OP_LIST) random_done++;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all requests out, then all results back, then a quiet tail
    while (send_queue.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("record_deque_top: match");
    end else begin
      $display("record_deque_top: mismatch");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("record_deque_top: mismatch");
    $finish;
  end

endmodule
